@@ hw/rtl/bsad_pkg.sv @@
// package: shared widths, constants and types of the block sad accumulator
`default_nettype none

package bsad_pkg;

   // lane geometry
   localparam int LANES = 8;
   localparam int PIX_W = 8;
   localparam int BUS_W = LANES * PIX_W;

   // sum of one request across all lanes: 8 * 255 fits in 11 bits
   localparam int SUM_W = 11;

   // running total and its saturation point
   localparam int SAD_W = 20;
   localparam logic [SAD_W-1:0] SAD_MAX = '1;

   // block size register
   localparam int CFG_W = 3;
   localparam logic [CFG_W-1:0] CFG_RESET = 3'd3;
   localparam logic [CFG_W-1:0] MIN_BLOCK_LOG2 = 3'd2;

   // per-lane absolute differences
   typedef logic [PIX_W-1:0] diff_array_type [LANES];

endpackage : bsad_pkg

`default_nettype wire

@@ hw/rtl/bsad_lane.sv @@
// lane: absolute difference of one source and one reference pixel
`default_nettype none

module bsad_lane
   import bsad_pkg::*;
(
   input  wire logic [PIX_W-1:0] pix_a,
   input  wire logic [PIX_W-1:0] pix_b,
   output logic      [PIX_W-1:0] abs_diff
);

   // subtract the smaller from the larger
   always_comb begin
      if (pix_a > pix_b) begin
         abs_diff = pix_a - pix_b;
      end else begin
         abs_diff = pix_b - pix_a;
      end
   end

endmodule : bsad_lane

`default_nettype wire

@@ hw/rtl/bsad_merge.sv @@
// merge: adds the lane differences of one request into one partial sum
`default_nettype none

module bsad_merge
   import bsad_pkg::*;
(
   input  wire diff_array_type       diffs,
   output logic      [SUM_W-1:0]     lane_sum
);

   // sum over the eight lanes
   always_comb begin
      lane_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_sum = lane_sum + SUM_W'(diffs[i]);
      end
   end

endmodule : bsad_merge

`default_nettype wire

@@ hw/rtl/block_sad_accumulator.sv @@
// top level: block sad accumulator with eight lanes and a running total
`default_nettype none

// Sum of absolute differences over a square block of unsigned 8-bit pixels.
// Each request carries eight source and eight reference pixels in row-major
// order; a block of n x n pixels takes n*n/8 requests (2 for 4x4, 512 for
// 64x64) and produces one result with the block total, after which the total
// and the request count clear. A request is accepted every cycle while the
// result register is free or being taken: eight lanes form the differences
// into a stage register, and one accumulator adds their sum per cycle. The
// result is valid once the last request of a block has left the stage register.
// csr_block_size_log2 takes log2 of n; values below 2 act as 2 and values
// above MAX_BLOCK_LOG2 act as MAX_BLOCK_LOG2. A size change does not clear
// the count; the block ends at the first request that reaches or passes the
// request total of the size in force. The total saturates at its 20-bit max.
module block_sad_accumulator
   import bsad_pkg::*;
#(
   parameter int MAX_BLOCK_LOG2 = 6
)(
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CFG_W-1:0] csr_block_size_log2,

   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [BUS_W-1:0] req_src_pixels,
   input  wire logic [BUS_W-1:0] req_ref_pixels,

   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic      [SAD_W-1:0] rsp_sad_total
);

   // count width: stored count holds up to the largest total minus one
   localparam int CNT_W  = 2 * MAX_BLOCK_LOG2 - 3;
   localparam int CNTP_W = CNT_W + 1;
   localparam int SH_W   = 4;

   logic [CFG_W-1:0] cfg_ff;
   logic [CFG_W-1:0] cfg_in;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   diff_array_type   s1_diffs_ff;
   diff_array_type   lane_diffs;

   logic [SAD_W-1:0] acc_ff;
   logic [SAD_W-1:0] acc_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [SAD_W-1:0] rsp_total_ff;
   logic [SAD_W-1:0] rsp_total_in;

   logic [SUM_W-1:0]  lane_sum;
   logic [SAD_W:0]    sum_wide;
   logic [SAD_W-1:0]  sum_sat;
   logic [CFG_W-1:0]  eff_log2;
   logic [SH_W-1:0]   item_shift;
   logic [CNTP_W-1:0] items_need;
   logic [CNTP_W-1:0] count_next;
   logic              blk_done;
   logic              s1_fire;
   logic              req_fire;

   // configuration register, always ready
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         cfg_in = csr_block_size_log2;
      end
   end

   // lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      bsad_lane u_lane (
         .pix_a    (req_src_pixels[g*PIX_W +: PIX_W]),
         .pix_b    (req_ref_pixels[g*PIX_W +: PIX_W]),
         .abs_diff (lane_diffs[g])
      );
   end

   // merge of the registered lane differences
   bsad_merge u_merge (
      .diffs    (s1_diffs_ff),
      .lane_sum (lane_sum)
   );

   // handshake and stage advance
   assign s1_fire   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   // effective block size and request total
   always_comb begin
      if (cfg_ff < MIN_BLOCK_LOG2) begin
         eff_log2 = MIN_BLOCK_LOG2;
      end else if (cfg_ff > CFG_W'(MAX_BLOCK_LOG2)) begin
         eff_log2 = CFG_W'(MAX_BLOCK_LOG2);
      end else begin
         eff_log2 = cfg_ff;
      end
      item_shift = {eff_log2, 1'b0} - SH_W'(3);
      items_need = CNTP_W'(1) << item_shift;
      count_next = CNTP_W'(count_ff) + CNTP_W'(1);
      blk_done   = count_next >= items_need;
   end

   // saturating accumulate
   always_comb begin
      sum_wide = (SAD_W + 1)'(acc_ff) + (SAD_W + 1)'(lane_sum);
      if (sum_wide[SAD_W]) begin
         sum_sat = SAD_MAX;
      end else begin
         sum_sat = sum_wide[SAD_W-1:0];
      end
   end

   // next state of stage, accumulator and result
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      acc_in       = acc_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_fire) begin
         s1_valid_in = 1'b0;
         if (blk_done) begin
            acc_in       = '0;
            count_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_total_in = sum_sat;
         end else begin
            acc_in   = sum_sat;
            count_in = count_next[CNT_W-1:0];
         end
      end
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_diffs_ff <= lane_diffs;
      end
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sad_total = rsp_total_ff;

`ifndef SYNTHESIS
   // end of block clears the running state
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && blk_done) |=> (acc_ff == '0 && count_ff == '0 && rsp_valid_ff))
      else $error("running state not cleared after block end");

   // requests stall only behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled without a held result");

   // a stalled stage keeps its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(count_ff) && $stable(acc_ff)))
      else $error("stalled stage lost its request");
`endif

endmodule : block_sad_accumulator

`default_nettype wire
